// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define HPC_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
`define HPC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HPC_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg)
`define HPC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg)
`endif

`endif

// ===== sv/hpc_pkg.sv =====
// Shared constants, command codes and control types of the position corrector
package hpc_pkg;

    localparam int AXES      = 3;
    localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int NREG      = 2 * AXES;
    localparam int CFG_IDX_W = $clog2(NREG);
    localparam int VAL_W     = 32;
    localparam int DT_W      = 16;
    localparam int TIME_W    = 18;
    localparam int FRAC_W    = 16;
    localparam int COEF_W    = 36;
    localparam int FAC_W     = 18;
    localparam int PROD_W    = COEF_W + FAC_W + 1;
    localparam int ACC_W     = 56;

    localparam logic [TIME_W-1:0] HALF_SECOND = TIME_W'(32768);

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_SQ   = 3'd1;
    localparam logic [OP_W-1:0] OP_CUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_PA   = 3'd3;
    localparam logic [OP_W-1:0] OP_PB   = 3'd4;
    localparam logic [OP_W-1:0] OP_PC   = 3'd5;
    localparam logic [OP_W-1:0] OP_VA   = 3'd6;
    localparam logic [OP_W-1:0] OP_VB   = 3'd7;

    typedef struct packed {
        logic              capture;
        logic              load;
        logic              set_target;
        logic [OP_W-1:0]   op;
        logic              wb;
        logic              tick_done;
        logic              emit;
        logic [AXIS_W-1:0] axis;
    } hpc_cmd_t;

    typedef struct packed {
        logic have_target;
        logic active;
    } hpc_stat_t;

endpackage

// ===== sv/hpc_req_if.sv =====
// Input channel: tick or target word with valid/ready handshake
interface hpc_req_if;
    logic              valid;
    logic              ready;
    logic              action;
    logic [15:0]       dt;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] target_vx;
    logic signed [31:0] target_vy;
    logic signed [31:0] target_vz;

    modport source (
        output valid, action, dt, target_x, target_y, target_z,
               target_vx, target_vy, target_vz,
        input  ready
    );
    modport sink (
        input  valid, action, dt, target_x, target_y, target_z,
               target_vx, target_vy, target_vz,
        output ready
    );
endinterface

// ===== sv/hpc_rsp_if.sv =====
// Output channel: position and derivative word with valid/ready handshake
interface hpc_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
        output ready
    );
endinterface

// ===== sv/hpc_ctrl.sv =====
// Sequencer: steps coefficient load, curve evaluation and result hand-off
module hpc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_action,
    output logic                req_ready,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    input  hpc_pkg::hpc_stat_t  stat,
    output hpc_pkg::hpc_cmd_t   cmd
);
    import hpc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_SQW  = 4'd3;
    localparam logic [3:0] S_CUB  = 4'd4;
    localparam logic [3:0] S_CUBW = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DRN  = 4'd7;
    localparam logic [3:0] S_WB   = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);
    localparam logic [2:0]        LAST_STEP = 3'd4;

    logic [3:0]        state_reg, state_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic [2:0]        step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = accept;
                if (accept)
                begin
                    axis_next = '0;
                    step_next = '0;
                    if (req_action)
                        state_next = S_LOAD;
                    else if (stat.have_target && stat.active)
                        state_next = S_SQ;
                    else
                        state_next = S_EMIT;
                end
            end
            S_LOAD:
            begin
                cmd.load = 1'b1;
                if (axis_reg == LAST_AXIS)
                begin
                    cmd.set_target = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                    axis_next = axis_reg + 1'b1;
            end
            S_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_SQW;
            end
            S_SQW:
                state_next = S_CUB;
            S_CUB:
            begin
                cmd.op     = OP_CUB;
                state_next = S_CUBW;
            end
            S_CUBW:
                state_next = S_MUL;
            S_MUL:
            begin
                case (step_reg)
                    3'd0:    cmd.op = OP_PA;
                    3'd1:    cmd.op = OP_PB;
                    3'd2:    cmd.op = OP_PC;
                    3'd3:    cmd.op = OP_VA;
                    default: cmd.op = OP_VB;
                endcase
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = S_DRN;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            S_DRN:
                state_next = S_WB;
            S_WB:
            begin
                cmd.wb = 1'b1;
                if (axis_reg == LAST_AXIS)
                begin
                    cmd.tick_done = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = cmd.emit || (out_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/hpc_dp.sv =====
// Datapath: state, coefficients, shared multiplier, accumulators and result word
module hpc_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hpc_pkg::hpc_cmd_t                    cmd,
    output hpc_pkg::hpc_stat_t                   stat,
    input  logic                                 cfg_we,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic signed [hpc_pkg::VAL_W-1:0]     cfg_data,
    input  logic [hpc_pkg::DT_W-1:0]             in_dt,
    input  logic signed [hpc_pkg::VAL_W-1:0]     in_tgt_pos [hpc_pkg::AXES],
    input  logic signed [hpc_pkg::VAL_W-1:0]     in_tgt_vel [hpc_pkg::AXES],
    output logic signed [hpc_pkg::VAL_W-1:0]     res_pos [hpc_pkg::AXES],
    output logic signed [hpc_pkg::VAL_W-1:0]     res_vel [hpc_pkg::AXES]
);
    import hpc_pkg::*;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC_W - 1));
    localparam int SUM_W = ACC_W - FRAC_W + 1;

    logic signed [VAL_W-1:0]  start_reg [NREG];
    logic signed [VAL_W-1:0]  start_next [NREG];
    logic                     have_target_reg, have_target_next;
    logic [TIME_W-1:0]        elapsed_reg, elapsed_next;
    logic signed [VAL_W-1:0]  cur_pos_reg [AXES];
    logic signed [VAL_W-1:0]  cur_pos_next [AXES];
    logic signed [VAL_W-1:0]  cur_vel_reg [AXES];
    logic signed [VAL_W-1:0]  cur_vel_next [AXES];
    logic signed [COEF_W-1:0] coef_a_reg [AXES];
    logic signed [COEF_W-1:0] coef_a_next [AXES];
    logic signed [COEF_W-1:0] coef_b_reg [AXES];
    logic signed [COEF_W-1:0] coef_b_next [AXES];
    logic signed [VAL_W-1:0]  coef_c_reg [AXES];
    logic signed [VAL_W-1:0]  coef_c_next [AXES];
    logic signed [VAL_W-1:0]  coef_d_reg [AXES];
    logic signed [VAL_W-1:0]  coef_d_next [AXES];
    logic signed [VAL_W-1:0]  tgt_pos_reg [AXES];
    logic signed [VAL_W-1:0]  tgt_pos_next [AXES];
    logic signed [VAL_W-1:0]  tgt_vel_reg [AXES];
    logic signed [VAL_W-1:0]  tgt_vel_next [AXES];
    logic signed [VAL_W-1:0]  res_pos_reg [AXES];
    logic signed [VAL_W-1:0]  res_pos_next [AXES];
    logic signed [VAL_W-1:0]  res_vel_reg [AXES];
    logic signed [VAL_W-1:0]  res_vel_next [AXES];
    logic [DT_W-1:0]          dt_reg, dt_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [OP_W-1:0]          prod_op_reg, prod_op_next;
    logic [FRAC_W-1:0]        u2_reg, u2_next;
    logic [FRAC_W-1:0]        u3_reg, u3_next;
    logic [FAC_W-1:0]         u2x3_reg, u2x3_next;
    logic signed [ACC_W-1:0]  pos_acc_reg, pos_acc_next;
    logic signed [ACC_W-1:0]  vel_acc_reg, vel_acc_next;

    logic [FRAC_W-1:0]        u;
    logic signed [COEF_W-1:0] mul_a;
    logic [FAC_W-1:0]         mul_f;
    logic [2*FRAC_W:0]        prod_rnd;
    logic signed [COEF_W-1:0] p0e, p1e, v0e, v1e, dd;

    function automatic logic signed [VAL_W-1:0] rnd_sat(
        input logic signed [ACC_W-1:0] acc,
        input logic signed [VAL_W-1:0] base
    );
        logic signed [ACC_W-1:0] t;
        logic signed [SUM_W-1:0] s;
        logic signed [VAL_W-1:0] r;
        t = acc + RND_HALF;
        s = {t[ACC_W-1], t[ACC_W-1:FRAC_W]}
            + {{(SUM_W - VAL_W){base[VAL_W-1]}}, base};
        if (s[SUM_W-1:VAL_W-1] == '0 || s[SUM_W-1:VAL_W-1] == '1)
            r = s[VAL_W-1:0];
        else if (s[SUM_W-1])
            r = {1'b1, {(VAL_W-1){1'b0}}};
        else
            r = {1'b0, {(VAL_W-1){1'b1}}};
        return r;
    endfunction

    assign u                = {elapsed_reg[FRAC_W-2:0], 1'b0};
    assign stat.have_target = have_target_reg;
    assign stat.active      = (elapsed_reg < HALF_SECOND);
    assign prod_rnd         = prod_reg[2*FRAC_W:0] + (2*FRAC_W+1)'(1 << (FRAC_W - 1));

    always_comb
    begin
        case (cmd.op)
            OP_SQ:
            begin
                mul_a = COEF_W'(u);
                mul_f = FAC_W'(u);
            end
            OP_CUB:
            begin
                mul_a = COEF_W'(u2_reg);
                mul_f = FAC_W'(u);
            end
            OP_PA:
            begin
                mul_a = coef_a_reg[cmd.axis];
                mul_f = FAC_W'(u3_reg);
            end
            OP_PB:
            begin
                mul_a = coef_b_reg[cmd.axis];
                mul_f = FAC_W'(u2_reg);
            end
            OP_PC:
            begin
                mul_a = COEF_W'(coef_c_reg[cmd.axis]);
                mul_f = FAC_W'(u);
            end
            OP_VA:
            begin
                mul_a = coef_a_reg[cmd.axis];
                mul_f = u2x3_reg;
            end
            OP_VB:
            begin
                mul_a = coef_b_reg[cmd.axis];
                mul_f = FAC_W'({u, 1'b0});
            end
            default:
            begin
                mul_a = '0;
                mul_f = '0;
            end
        endcase
    end

    assign p0e = COEF_W'(cur_pos_reg[cmd.axis]);
    assign v0e = COEF_W'(cur_vel_reg[cmd.axis]);
    assign p1e = COEF_W'(tgt_pos_reg[cmd.axis]);
    assign v1e = COEF_W'(tgt_vel_reg[cmd.axis]);
    assign dd  = p1e - p0e;

    always_comb
    begin
        start_next       = start_reg;
        have_target_next = have_target_reg;
        elapsed_next     = elapsed_reg;
        cur_pos_next     = cur_pos_reg;
        cur_vel_next     = cur_vel_reg;
        coef_a_next      = coef_a_reg;
        coef_b_next      = coef_b_reg;
        coef_c_next      = coef_c_reg;
        coef_d_next      = coef_d_reg;
        tgt_pos_next     = tgt_pos_reg;
        tgt_vel_next     = tgt_vel_reg;
        res_pos_next     = res_pos_reg;
        res_vel_next     = res_vel_reg;
        dt_next          = dt_reg;
        u2_next          = u2_reg;
        u3_next          = u3_reg;
        u2x3_next        = u2x3_reg;
        pos_acc_next     = pos_acc_reg;
        vel_acc_next     = vel_acc_reg;

        prod_next    = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_f}));
        prod_op_next = cmd.op;

        if (cmd.capture)
        begin
            tgt_pos_next = in_tgt_pos;
            tgt_vel_next = in_tgt_vel;
            dt_next      = in_dt;
        end

        if (cmd.load)
        begin
            coef_a_next[cmd.axis] = v0e + v1e - (dd <<< 1);
            coef_b_next[cmd.axis] = (dd <<< 1) + dd - (v0e <<< 1) - v1e;
            coef_c_next[cmd.axis] = cur_vel_reg[cmd.axis];
            coef_d_next[cmd.axis] = cur_pos_reg[cmd.axis];
        end
        if (cmd.set_target)
        begin
            have_target_next = 1'b1;
            elapsed_next     = '0;
        end

        case (prod_op_reg)
            OP_SQ:
                u2_next = prod_rnd[2*FRAC_W-1:FRAC_W];
            OP_CUB:
            begin
                u3_next   = prod_rnd[2*FRAC_W-1:FRAC_W];
                u2x3_next = FAC_W'(u2_reg) + FAC_W'({u2_reg, 1'b0});
            end
            OP_PA:
                pos_acc_next = ACC_W'(prod_reg);
            OP_PB, OP_PC:
                pos_acc_next = pos_acc_reg + ACC_W'(prod_reg);
            OP_VA:
                vel_acc_next = ACC_W'(prod_reg);
            OP_VB:
                vel_acc_next = vel_acc_reg + ACC_W'(prod_reg);
            default:
            begin
            end
        endcase

        if (cmd.wb)
        begin
            cur_pos_next[cmd.axis] = rnd_sat(pos_acc_reg, coef_d_reg[cmd.axis]);
            cur_vel_next[cmd.axis] = rnd_sat(vel_acc_reg, coef_c_reg[cmd.axis]);
        end
        if (cmd.tick_done)
            elapsed_next = elapsed_reg + TIME_W'(dt_reg);

        if (cmd.emit)
        begin
            res_pos_next = cur_pos_reg;
            res_vel_next = cur_vel_reg;
        end

        if (cfg_we)
        begin
            for (int j = 0; j < NREG; j++)
            begin
                if (cfg_idx == CFG_IDX_W'(j))
                    start_next[j] = cfg_data;
            end
            if (!have_target_reg)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    if (cfg_idx == CFG_IDX_W'(i))
                        cur_pos_next[i] = cfg_data;
                    if (cfg_idx == CFG_IDX_W'(AXES + i))
                        cur_vel_next[i] = cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_target_reg <= 1'b0;
            elapsed_reg     <= '0;
            prod_op_reg     <= OP_NONE;
            for (int j = 0; j < NREG; j++)
                start_reg[j] <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                cur_pos_reg[i] <= '0;
                cur_vel_reg[i] <= '0;
            end
        end
        else
        begin
            have_target_reg <= have_target_next;
            elapsed_reg     <= elapsed_next;
            prod_op_reg     <= prod_op_next;
            start_reg       <= start_next;
            cur_pos_reg     <= cur_pos_next;
            cur_vel_reg     <= cur_vel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_a_reg  <= coef_a_next;
        coef_b_reg  <= coef_b_next;
        coef_c_reg  <= coef_c_next;
        coef_d_reg  <= coef_d_next;
        tgt_pos_reg <= tgt_pos_next;
        tgt_vel_reg <= tgt_vel_next;
        res_pos_reg <= res_pos_next;
        res_vel_reg <= res_vel_next;
        dt_reg      <= dt_next;
        prod_reg    <= prod_next;
        u2_reg      <= u2_next;
        u3_reg      <= u3_next;
        u2x3_reg    <= u2x3_next;
        pos_acc_reg <= pos_acc_next;
        vel_acc_reg <= vel_acc_next;
    end

    assign res_pos = res_pos_reg;
    assign res_vel = res_vel_reg;

endmodule

// ===== sv/cubic_hermite_position_correction.sv =====
// Top level: cubic Hermite position corrector, Q16.16, three axes
//
// Usage: a word on req is either a target (action = 1: target position and
// velocity) or a time tick (action = 0: dt in Q0.16 seconds). Every accepted
// word returns exactly one word on rsp with the current position and its
// derivative. Start position and velocity are written through cfg_we,
// cfg_idx, cfg_data while the block is idle.
// One word is processed at a time; req.ready is high only when the sequencer is idle.
// A target loads the coefficients of each axis and goes to the output register;
// a tick that evaluates the curve runs on the single shared 36x19 multiplier:
// two products for u^2 and u^3, then five products, a drain and a write-back
// for each axis; a tick that changes nothing goes straight to the output
// register.
// A finished word waits in an output register; while rsp.ready is low the
// block holds that word and finishes the next item only once it is taken.
// Reset clears the start registers, position, velocity and timer to zero;
// no item is pending after reset.
`include "assert_macros.svh"

module cubic_hermite_position_correction (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic signed [hpc_pkg::VAL_W-1:0]   cfg_data,
    hpc_req_if.sink                            req,
    hpc_rsp_if.source                          rsp
);
    import hpc_pkg::*;

    hpc_cmd_t                cmd;
    hpc_stat_t               stat;
    logic signed [VAL_W-1:0] tgt_pos [AXES];
    logic signed [VAL_W-1:0] tgt_vel [AXES];
    logic signed [VAL_W-1:0] res_pos [AXES];
    logic signed [VAL_W-1:0] res_vel [AXES];

    assign tgt_pos[0] = req.target_x;
    assign tgt_pos[1] = req.target_y;
    assign tgt_pos[2] = req.target_z;
    assign tgt_vel[0] = req.target_vx;
    assign tgt_vel[1] = req.target_vy;
    assign tgt_vel[2] = req.target_vz;

    hpc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .rsp_ready  (rsp.ready),
        .rsp_valid  (rsp.valid),
        .stat       (stat),
        .cmd        (cmd)
    );

    hpc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .in_dt      (req.dt),
        .in_tgt_pos (tgt_pos),
        .in_tgt_vel (tgt_vel),
        .res_pos    (res_pos),
        .res_vel    (res_vel)
    );

    assign rsp.pos_x = res_pos[0];
    assign rsp.pos_y = res_pos[1];
    assign rsp.pos_z = res_pos[2];
    assign rsp.vel_x = res_vel[0];
    assign rsp.vel_y = res_vel[1];
    assign rsp.vel_z = res_vel[2];

    `HPC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, !req.ready, "input taken while an item is in flight")
    `HPC_ASSERT_SAME(a_emit_free, clk, rst_n, cmd.emit, !rsp.valid || rsp.ready, "result overwrites a waiting word")
    `HPC_ASSERT_SAME(a_wb_has_target, clk, rst_n, cmd.wb, stat.have_target && stat.active, "curve write-back without a running curve")
    `HPC_ASSERT_SAME(a_load_no_mul, clk, rst_n, cmd.load, cmd.op == OP_NONE && !cmd.wb, "coefficient load overlaps evaluation")

endmodule
